### hw/rtl/ssd_ii_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_ii_pkg
// shared types and constants of the squared-difference integral image block
// ----------------------------------------------------------------------------
package ssd_ii_pkg;

  localparam int MAX_ROW_DEFAULT = 4096;

  localparam int PIXEL_W    = 8;
  localparam int INTEGRAL_W = 32;
  localparam int ROW_LEN_W  = 13;
  localparam int ROW_CNT_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = ROW_LEN_W'(64);
  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET  = ROW_CNT_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_ROW_COUNT  = 2'd1
  } cfg_reg_t;

endpackage
`default_nettype wire

### hw/rtl/ssd_ii_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_ii_in_if
// pixel pair channel: centred and shifted pixel with valid/ready
// ----------------------------------------------------------------------------
interface ssd_ii_in_if;
  logic                             valid;
  logic                             ready;
  logic [ssd_ii_pkg::PIXEL_W-1:0]   pixel_centre;
  logic [ssd_ii_pkg::PIXEL_W-1:0]   pixel_shifted;

  modport source (output valid, output pixel_centre, output pixel_shifted, input ready);
  modport sink   (input valid, input pixel_centre, input pixel_shifted, output ready);
endinterface
`default_nettype wire

### hw/rtl/ssd_ii_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_ii_out_if
// result channel: integral value with row and frame end marks
// ----------------------------------------------------------------------------
interface ssd_ii_out_if;
  logic                               valid;
  logic                               ready;
  logic [ssd_ii_pkg::INTEGRAL_W-1:0]  ssd_integral;
  logic                               row_end;
  logic                               frame_end;

  modport source (output valid, output ssd_integral, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input ssd_integral, input row_end, input frame_end,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/ssd_ii_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_ii_cfg_if
// configuration write channel: register index and data with valid/ready
// ----------------------------------------------------------------------------
interface ssd_ii_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ssd_ii_pkg::CFG_IDX_W-1:0]   index;
  logic [ssd_ii_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/ssd_integral_image.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_integral_image
// streaming integral image of squared pixel differences in raster order
// a result passes stage a and then the result register after its request is accepted
// throughput: one request per cycle unless results stall, set by the single line buffer
// ram (one read and one write per pixel); a back-to-back column repeat is forwarded
// reset clears position counters, row sum and pipeline valids, and sets
// row_length and row_count to 64; the line buffer is not cleared
// ----------------------------------------------------------------------------
module ssd_integral_image #(
  parameter int MAX_ROW = ssd_ii_pkg::MAX_ROW_DEFAULT
) (
  input wire logic    clk,
  input wire logic    rst,
  ssd_ii_in_if.sink   pixels,
  ssd_ii_out_if.source results,
  ssd_ii_cfg_if.sink  cfg
);

  localparam int ColW = $clog2(MAX_ROW);
  localparam int LenW = ($clog2(MAX_ROW + 1) > ssd_ii_pkg::ROW_LEN_W) ?
                        $clog2(MAX_ROW + 1) : ssd_ii_pkg::ROW_LEN_W;
  localparam int IntW = ssd_ii_pkg::INTEGRAL_W;
  localparam int PixW = ssd_ii_pkg::PIXEL_W;

  // configuration
  logic [ssd_ii_pkg::ROW_LEN_W-1:0] row_length;
  logic [ssd_ii_pkg::ROW_CNT_W-1:0] row_count;

  // position and row accumulator
  logic [ColW-1:0]                  col_idx;
  logic [ssd_ii_pkg::ROW_CNT_W-1:0] row_idx;
  logic [IntW-1:0]                  row_sum;

  // stage a
  logic            a_valid;
  logic [ColW-1:0] a_col;
  logic [IntW-1:0] a_sum;
  logic            a_above_en;
  logic            a_last_col;
  logic            a_last_row;
  logic            a_fwd;
  logic [IntW-1:0] a_fwd_val;

  // result register
  logic            out_valid;
  logic [IntW-1:0] out_integral;
  logic            out_row_end;
  logic            out_frame_end;

  logic                             accept;
  logic                             a_advance;
  logic                             in_ready;
  logic [LenW-1:0]                  len_ext;
  logic [LenW-1:0]                  len_eff;
  logic [ssd_ii_pkg::ROW_CNT_W-1:0] cnt_eff;
  logic                             last_col;
  logic                             last_row;
  logic [PixW-1:0]                  diff;
  logic [2*PixW-1:0]                sq;
  logic [IntW-1:0]                  sum_next;
  logic [IntW-1:0]                  rd_data;
  logic [IntW-1:0]                  above;
  logic [IntW-1:0]                  value;

  assign a_advance = a_valid && (!out_valid || results.ready);
  assign in_ready  = !a_valid || a_advance;
  assign accept    = pixels.valid && in_ready;

  assign pixels.ready = in_ready;
  assign cfg.ready    = 1'b1;

  assign results.valid        = out_valid;
  assign results.ssd_integral = out_integral;
  assign results.row_end      = out_row_end;
  assign results.frame_end    = out_frame_end;

  // effective sizes and end-of-row / end-of-frame
  always_comb begin
    len_ext = LenW'(row_length);
    if (row_length == '0) begin
      len_eff = LenW'(1);
    end else if (len_ext > LenW'(MAX_ROW)) begin
      len_eff = LenW'(MAX_ROW);
    end else begin
      len_eff = len_ext;
    end
    cnt_eff  = (row_count == '0) ? ssd_ii_pkg::ROW_CNT_W'(1) : row_count;
    last_col = LenW'(col_idx) >= (len_eff - LenW'(1));
    last_row = row_idx >= (cnt_eff - ssd_ii_pkg::ROW_CNT_W'(1));
  end

  // squared difference and running row sum
  always_comb begin
    diff = (pixels.pixel_centre >= pixels.pixel_shifted) ?
           (pixels.pixel_centre - pixels.pixel_shifted) :
           (pixels.pixel_shifted - pixels.pixel_centre);
    sq       = {{PixW{1'b0}}, diff} * {{PixW{1'b0}}, diff};
    sum_next = row_sum + IntW'(sq);
  end

  // value of the row above plus row sum
  always_comb begin
    above = a_fwd ? a_fwd_val : rd_data;
    value = (a_above_en ? above : '0) + a_sum;
  end

  ssd_ii_ram #(
    .Width (IntW),
    .Depth (MAX_ROW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (a_advance),
    .wr_addr (a_col),
    .wr_data (value),
    .rd_en   (accept),
    .rd_addr (col_idx),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ssd_ii_pkg::ROW_LENGTH_RESET;
      row_count  <= ssd_ii_pkg::ROW_COUNT_RESET;
      col_idx    <= '0;
      row_idx    <= '0;
      row_sum    <= '0;
      a_valid    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == ssd_ii_pkg::REG_ROW_LENGTH) begin
          row_length <= cfg.data[ssd_ii_pkg::ROW_LEN_W-1:0];
        end else if (cfg.index == ssd_ii_pkg::REG_ROW_COUNT) begin
          row_count <= cfg.data[ssd_ii_pkg::ROW_CNT_W-1:0];
        end
      end

      if (accept) begin
        if (last_col) begin
          col_idx <= '0;
          row_sum <= '0;
          row_idx <= last_row ? '0 : row_idx + ssd_ii_pkg::ROW_CNT_W'(1);
        end else begin
          col_idx <= col_idx + ColW'(1);
          row_sum <= sum_next;
        end
      end

      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_advance) begin
        a_valid <= 1'b0;
      end

      if (a_advance) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      a_col      <= col_idx;
      a_sum      <= sum_next;
      a_above_en <= (row_idx != '0);
      a_last_col <= last_col;
      a_last_row <= last_row;
      // previous request writes the column this one reads
      a_fwd      <= a_advance && (a_col == col_idx);
      a_fwd_val  <= value;
    end
    if (a_advance) begin
      out_integral  <= value;
      out_row_end   <= a_last_col;
      out_frame_end <= a_last_col && a_last_row;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ssd_ii_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_ii_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ssd_ii_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the squared-difference integral image block:
// a queue-fed pixel driver and a result monitor with random idle bursts on
// both sides, a predictor of the line buffer and row sum, and
// configuration phases that sweep row length and row count, including the
// saturated, zero and mid-frame cases
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_ROW        = ssd_ii_pkg::MAX_ROW_DEFAULT;
  localparam int PIXEL_W        = ssd_ii_pkg::PIXEL_W;
  localparam int INTEGRAL_W     = ssd_ii_pkg::INTEGRAL_W;
  localparam int ROW_LEN_W      = ssd_ii_pkg::ROW_LEN_W;
  localparam int ROW_CNT_W      = ssd_ii_pkg::ROW_CNT_W;
  localparam int CFG_IDX_W      = ssd_ii_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = ssd_ii_pkg::CFG_DATA_W;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int QUIET_ITEMS    = 200;
  localparam int WIDE_ITEMS     = 64;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PIXEL_W-1:0] centre;
    logic [PIXEL_W-1:0] shifted;
  } pixel_pair_t;

  typedef struct packed {
    logic [INTEGRAL_W-1:0] integral;
    logic                  row_end;
    logic                  frame_end;
  } integral_t;

  logic clk = 1'b0;
  logic rst;

  ssd_ii_in_if  pixels_if ();
  ssd_ii_out_if results_if ();
  ssd_ii_cfg_if cfg_if ();

  ssd_integral_image #(.MAX_ROW(MAX_ROW)) dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [ROW_LEN_W-1:0]  row_length_q;
  logic [ROW_CNT_W-1:0]  row_count_q;
  logic [INTEGRAL_W-1:0] row_sum;
  logic [INTEGRAL_W-1:0] line_mem [MAX_ROW];
  int                    col_idx;
  logic [ROW_CNT_W-1:0]  row_idx;
  int                    line_top;

  pixel_pair_t pixel_backlog [$];
  integral_t   integral_due [$];

  int  pairs_queued;
  int  pairs_taken;
  int  integrals_seen;
  int  mismatches;
  bit  quiet;
  bit  in_taken;
  int  in_gap;
  int  out_gap;
  int  hold_left;
  bit  hold_request;

  function automatic int eff_length(input logic [ROW_LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_ROW) return MAX_ROW;
    return int'(len);
  endfunction

  function automatic int eff_count(input logic [ROW_CNT_W-1:0] cnt);
    return (cnt == 0) ? 1 : int'(cnt);
  endfunction

  function automatic int frame_remaining();
    int len;
    int cnt;
    int in_row;
    int rows_after;
    len = eff_length(row_length_q);
    cnt = eff_count(row_count_q);
    in_row = (col_idx >= len - 1) ? 1 : len - col_idx;
    rows_after = (int'(row_idx) >= cnt - 1) ? 0 : cnt - 1 - int'(row_idx);
    return in_row + rows_after * len;
  endfunction

  task automatic integrate_pixel(input logic [PIXEL_W-1:0] centre,
                                 input logic [PIXEL_W-1:0] shifted);
    logic [PIXEL_W-1:0]    diff;
    logic [INTEGRAL_W-1:0] above;
    integral_t             res;
    int                    len;
    int                    cnt;
    int                    col;
    bit                    last_col;
    bit                    last_row;
    diff = (centre >= shifted) ? centre - shifted : shifted - centre;
    len = eff_length(row_length_q);
    cnt = eff_count(row_count_q);
    col = (col_idx >= MAX_ROW) ? MAX_ROW - 1 : col_idx;
    row_sum = row_sum + INTEGRAL_W'(diff) * INTEGRAL_W'(diff);
    above = (row_idx != 0) ? line_mem[col] : '0;
    res.integral = above + row_sum;
    line_mem[col] = res.integral;
    if (col > line_top) line_top = col;
    last_col = (col >= len - 1);
    last_row = (int'(row_idx) >= cnt - 1);
    if (last_col) begin
      col_idx = 0;
      row_sum = '0;
      row_idx = last_row ? '0 : row_idx + 1'b1;
    end else begin
      col_idx = col + 1;
    end
    res.row_end = last_col;
    res.frame_end = last_col && last_row;
    integral_due.push_back(res);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      row_length_q = ssd_ii_pkg::ROW_LENGTH_RESET;
      row_count_q = ssd_ii_pkg::ROW_COUNT_RESET;
      row_sum = '0;
      col_idx = 0;
      row_idx = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == ssd_ii_pkg::REG_ROW_LENGTH)
          row_length_q = cfg_if.data[ROW_LEN_W-1:0];
        else if (cfg_if.index == ssd_ii_pkg::REG_ROW_COUNT)
          row_count_q = cfg_if.data[ROW_CNT_W-1:0];
      end
      if (pixels_if.valid && pixels_if.ready) begin
        integrate_pixel(pixels_if.pixel_centre, pixels_if.pixel_shifted);
        pairs_taken++;
        in_taken = 1'b1;
      end
    end
  end

  // pixel request driver
  always @(negedge clk) begin
    pixel_pair_t p;
    if (rst) begin
      pixels_if.valid <= 1'b0;
    end else if (!pixels_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        pixels_if.valid <= 1'b0;
      end else if (pixel_backlog.size() == 0) begin
        pixels_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 7);
        pixels_if.valid <= 1'b0;
      end else begin
        p = pixel_backlog.pop_front();
        pixels_if.valid <= 1'b1;
        pixels_if.pixel_centre <= p.centre;
        pixels_if.pixel_shifted <= p.shifted;
      end
    end
  end

  // result ready with bursts and long holds
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      results_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(0, 7);
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    integral_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      integrals_seen++;
      if (integral_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", results_if.ssd_integral));
      end else begin
        want = integral_due.pop_front();
        if (results_if.ssd_integral !== want.integral)
          report_mismatch($sformatf("result %0d ssd_integral %h want %h", integrals_seen,
                                    results_if.ssd_integral, want.integral));
        if (results_if.row_end !== want.row_end)
          report_mismatch($sformatf("result %0d row_end %b want %b", integrals_seen,
                                    results_if.row_end, want.row_end));
        if (results_if.frame_end !== want.frame_end)
          report_mismatch($sformatf("result %0d frame_end %b want %b", integrals_seen,
                                    results_if.frame_end, want.frame_end));
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (pixels_if.valid && pixels_if.ready) || (results_if.valid && results_if.ready)
          || (cfg_if.valid && cfg_if.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic queue_pair(input logic [PIXEL_W-1:0] centre,
                            input logic [PIXEL_W-1:0] shifted);
    pixel_backlog.push_back('{centre, shifted});
    pairs_queued++;
  endtask

  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    p.centre = PIXEL_W'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: p.shifted = p.centre;
      1: p.shifted = p.centre + PIXEL_W'($urandom_range(0, 6)) - PIXEL_W'(3);
      2: begin
        p.centre = $urandom_range(0, 1) ? '1 : '0;
        p.shifted = ~p.centre;
      end
      default: p.shifted = PIXEL_W'($urandom_range(0, 255));
    endcase
    return p;
  endfunction

  task automatic queue_random(input int n);
    pixel_pair_t p;
    repeat (n) begin
      p = random_pair();
      queue_pair(p.centre, p.shifted);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pairs_taken != pairs_queued || integrals_seen != pairs_taken);
  endtask

  // a longer row is only allowed mid-frame if the line buffer already holds it
  task automatic configure(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] v;
    v = value;
    if (idx == ssd_ii_pkg::REG_ROW_LENGTH && row_idx != 0 &&
        eff_length(v[ROW_LEN_W-1:0]) - 1 > line_top)
      v = CFG_DATA_W'(line_top + 1);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    do @(posedge clk);
    while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_length();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 19))
      0: v = '0;
      1: v = '1;
      2: v = CFG_DATA_W'(MAX_ROW);
      3, 4, 5: v = CFG_DATA_W'($urandom_range(13, 100));
      default: v = CFG_DATA_W'($urandom_range(1, 12));
    endcase
    v[CFG_DATA_W-1:ROW_LEN_W] = (CFG_DATA_W-ROW_LEN_W)'(
        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0);
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_count();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return '1;
      2, 3: return CFG_DATA_W'($urandom_range(9, 300));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    int n;
    int random_items;
    rst = 1'b1;
    pixels_if.valid = 1'b0;
    pixels_if.pixel_centre = '0;
    pixels_if.pixel_shifted = '0;
    results_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = ssd_ii_pkg::REG_ROW_LENGTH;
    cfg_if.data = '0;
    pairs_queued = 0;
    pairs_taken = 0;
    integrals_seen = 0;
    mismatches = 0;
    quiet = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    out_gap = 0;
    hold_left = 0;
    hold_request = 1'b0;
    line_top = -1;
    random_items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset geometry, pixel extremes
    queue_pair(8'h00, 8'h00);
    queue_pair(8'hFF, 8'h00);
    queue_pair(8'h00, 8'hFF);
    queue_pair(8'hFF, 8'hFF);
    queue_pair(8'h80, 8'h7F);
    queue_pair(8'h01, 8'hFE);
    wait_drained();
    // shrink mid-row, zero length and zero count
    configure(ssd_ii_pkg::REG_ROW_LENGTH, '0);
    configure(ssd_ii_pkg::REG_ROW_COUNT, '0);
    queue_pair(8'hAA, 8'h55);
    queue_pair(8'h55, 8'hAA);
    wait_drained();
    // single column, repeated line buffer address
    configure(ssd_ii_pkg::REG_ROW_COUNT, 16'd3);
    repeat (4) queue_pair(8'hFF, 8'h00);
    wait_drained();
    configure(ssd_ii_pkg::REG_ROW_LENGTH, 16'd3);
    configure(ssd_ii_pkg::REG_ROW_COUNT, 16'd2);
    repeat (5) queue_pair(8'h00, 8'hFF);
    wait_drained();
    // tallest frame, then shrink the count below the current row
    configure(ssd_ii_pkg::REG_ROW_COUNT, '1);
    configure(ssd_ii_pkg::REG_ROW_LENGTH, 16'd2);
    queue_random(6);
    wait_drained();
    configure(ssd_ii_pkg::REG_ROW_COUNT, 16'd1);
    queue_random(3);
    wait_drained();
    // writes outside the register list
    configure(REG_SPARE_2, '1);
    configure(REG_SPARE_3, '0);
    queue_random(2);
    wait_drained();

    // saturated row length, with a long receiver hold and a sender pause
    n = frame_remaining();
    queue_random(n);
    wait_drained();
    configure(ssd_ii_pkg::REG_ROW_LENGTH, '1);
    hold_request = 1'b1;
    queue_random(WIDE_ITEMS);
    wait_drained();
    queue_random(WIDE_ITEMS);
    wait_drained();
    configure(ssd_ii_pkg::REG_ROW_LENGTH, CFG_DATA_W'(MAX_ROW));
    configure(ssd_ii_pkg::REG_ROW_COUNT, 16'd2);
    queue_random(5);
    wait_drained();

    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      case ($urandom_range(0, 11))
        0, 1: configure(ssd_ii_pkg::REG_ROW_LENGTH, random_length());
        2, 3: configure(ssd_ii_pkg::REG_ROW_COUNT, random_count());
        4, 5: begin
          configure(ssd_ii_pkg::REG_ROW_COUNT, random_count());
          configure(ssd_ii_pkg::REG_ROW_LENGTH, random_length());
        end
        6: configure($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                     CFG_DATA_W'($urandom_range(0, 65535)));
        default: ;
      endcase
      n = frame_remaining();
      if (n > 150 || $urandom_range(0, 2) == 0) n = $urandom_range(1, 60);
      if (!quiet && $urandom_range(0, 15) == 0) hold_request = 1'b1;
      queue_random(n);
      random_items += n;
      wait_drained();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (integral_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", integral_due.size()));
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
